FILE: rtl/lplr_pkg.sv
// Shared types, constants and helpers for the four-pole ladder lowpass with ramped controls.
// No dependencies; every other file in rtl/ uses it by scoped names.
package lplr_pkg;

   localparam int LPLR_SAMPLE_BITS = 24;
   localparam int LPLR_CHANNELS    = 2;

   localparam int LPLR_CSR_IDX_W  = 3;
   localparam int LPLR_CSR_DATA_W = 32;

   // Shared multiplier: 34 x 34 signed operands, full product
   localparam int LPLR_OP_W   = 34;
   localparam int LPLR_PROD_W = 2 * LPLR_OP_W;

   // Unsigned Q1.30 coefficients
   localparam logic [30:0] K_116   = 31'd1245540516;
   localparam logic [30:0] K_015   = 31'd161061274;
   localparam logic [30:0] K_035   = 31'd375949225;
   localparam logic [30:0] K_030   = 31'd322122547;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   localparam logic [31:0] CUTOFF_START_RST = 32'h8000_0000;

   typedef enum logic [LPLR_CSR_IDX_W-1:0] {
      CSR_CHANNEL_MODE    = 3'd0,
      CSR_CUTOFF_START    = 3'd1,
      CSR_CUTOFF_SLOPE    = 3'd2,
      CSR_CUTOFF_CURVE    = 3'd3,
      CSR_RESONANCE_START = 3'd4,
      CSR_RESONANCE_SLOPE = 3'd5,
      CSR_RESONANCE_CURVE = 3'd6
   } lplr_csr_type;

   typedef struct packed {
      logic signed [LPLR_SAMPLE_BITS-1:0] sample_left;
      logic signed [LPLR_SAMPLE_BITS-1:0] sample_right;
      logic                               first_of_block;
   } lplr_req_type;

   typedef struct packed {
      logic signed [LPLR_SAMPLE_BITS-1:0] filtered_left;
      logic signed [LPLR_SAMPLE_BITS-1:0] filtered_right;
   } lplr_rsp_type;

   typedef struct packed {
      logic               channel_mode;
      logic        [31:0] cutoff_start;
      logic signed [31:0] cutoff_slope;
      logic signed [31:0] cutoff_curve;
      logic        [31:0] resonance_start;
      logic signed [31:0] resonance_slope;
      logic signed [31:0] resonance_curve;
   } lplr_cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COEF,
      ST_LANE,
      ST_FINISH
   } lplr_state_type;

   // Operand pair issued to the shared multiplier
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CUT_K116,
      OP_F_F,
      OP_F2_F2,
      OP_K015_F2,
      OP_K035_F4,
      OP_RES_V,
      OP_OUT3_FB,
      OP_X_G,
      OP_K030_IN,
      OP_D_OUT
   } lplr_mop_type;

   // What to do with the product registered in the previous cycle
   typedef enum logic [3:0] {
      USE_NONE,
      USE_F,
      USE_F2,
      USE_F4,
      USE_V,
      USE_G,
      USE_FB,
      USE_X0,
      USE_XG,
      USE_ACC,
      USE_POLE
   } lplr_use_type;

   typedef struct packed {
      lplr_mop_type mop;
      lplr_use_type use_op;
      logic [1:0]   rd_pole;
      logic [1:0]   wr_pole;
      logic         lane;
   } lplr_ctrl_type;

   typedef struct packed {
      logic busy;
      logic finish;
   } lplr_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [35:0] hi;
      logic signed [35:0] lo;
      hi = 36'sd2147483647;
      lo = -36'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [LPLR_SAMPLE_BITS-1:0] sat_sample(
      input logic signed [31:0] v);
      logic signed [32:0] smax;
      logic signed [32:0] smin;
      logic signed [32:0] w;
      smax = 33'((64'sd1 <<< (LPLR_SAMPLE_BITS - 1)) - 64'sd1);
      smin = -smax - 33'sd1;
      w    = 33'(v);
      if (w > smax) begin
         w = smax;
      end else if (w < smin) begin
         w = smin;
      end
      return w[LPLR_SAMPLE_BITS-1:0];
   endfunction

endpackage

FILE: rtl/ladder_lowpass_with_ramp_top.sv
// Top level of the four-pole ladder lowpass with ramped cutoff and resonance.
// Depends on lplr_pkg, lplr_mul, lplr_ramp and lplr_seq.
//
//   channel   ports                               direction  beat
//   request   req_valid, req_stall, req_data      in         one sample frame
//   response  rsp_valid, rsp_stall, rsp_data      out        one filtered frame
//   control   csr_wr_en, csr_index, csr_wr_data   in         one register write
//
// A frame occupies the block for 9 coefficient steps, 11 steps per lane and a
// hand-over state, which holds while the response side stalls a finished
// result; the next frame is taken in the idle state. All steps are paced by
// the one shared 34 x 34 multiplier, which yields a product a cycle.
// req_stall is high from the accepting edge until the frame is handed over.
// Synchronous reset clears both channels' pole state, ramps, config and rsp_valid.
module ladder_lowpass_with_ramp_top #(
   parameter int CHANNELS = lplr_pkg::LPLR_CHANNELS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  lplr_pkg::lplr_req_type                  req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output lplr_pkg::lplr_rsp_type                  rsp_data,
   input  logic                                    csr_wr_en,
   input  logic [lplr_pkg::LPLR_CSR_IDX_W-1:0]     csr_index,
   input  logic [lplr_pkg::LPLR_CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int  NPOLE     = 4 * CHANNELS;
   localparam int  ADDR_W    = $clog2(NPOLE);
   localparam bit  HAS_RIGHT = (CHANNELS > 1);
   localparam int  OPW       = lplr_pkg::LPLR_OP_W;
   localparam int  SB        = lplr_pkg::LPLR_SAMPLE_BITS;

   lplr_pkg::lplr_cfg_type  cfg_ff;
   lplr_pkg::lplr_req_type  smp_ff;
   lplr_pkg::lplr_rsp_type  rsp_data_ff;
   logic                    rsp_valid_ff;
   lplr_pkg::lplr_ctrl_type ctrl;
   lplr_pkg::lplr_stat_type stat;

   logic                     req_acc;
   logic                     stereo;
   logic                     out_free;
   logic [31:0]              cutoff_now;
   logic [31:0]              resonance_now;

   // coefficients of the current frame
   logic        [30:0] f_ff;
   logic signed [31:0] d_ff;
   logic        [30:0] f2_ff;
   logic        [30:0] f4_ff;
   logic        [30:0] v_ff;
   logic        [29:0] g_ff;
   logic        [31:0] fb_ff;

   // lane working registers
   logic signed [31:0]    x_ff;
   logic signed [31:0]    acc_ff;
   logic signed [SB-1:0]  left_ff;
   logic signed [SB-1:0]  right_ff;

   logic signed [31:0] pout_ff [NPOLE];
   logic signed [31:0] pin_ff  [NPOLE];
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic signed [31:0] pout_rd;
   logic signed [31:0] pin_rd;

   logic signed [OPW-1:0]                     op_a;
   logic signed [OPW-1:0]                     op_b;
   logic                                      mul_en;
   logic signed [lplr_pkg::LPLR_PROD_W-1:0]   prod;
   logic signed [37:0]                        psh;
   logic signed [SB-1:0]                      sample_sel;
   logic signed [31:0]                        x0;
   logic signed [35:0]                        ysum;
   logic signed [31:0]                        y;
   logic signed [SB-1:0]                      y_smp;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = stat.busy;
   assign stereo    = cfg_ff.channel_mode && HAS_RIGHT;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_mode    <= 1'b0;
         cfg_ff.cutoff_start    <= lplr_pkg::CUTOFF_START_RST;
         cfg_ff.cutoff_slope    <= '0;
         cfg_ff.cutoff_curve    <= '0;
         cfg_ff.resonance_start <= '0;
         cfg_ff.resonance_slope <= '0;
         cfg_ff.resonance_curve <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lplr_pkg::CSR_CHANNEL_MODE:    cfg_ff.channel_mode    <= csr_wr_data[0];
            lplr_pkg::CSR_CUTOFF_START:    cfg_ff.cutoff_start    <= csr_wr_data;
            lplr_pkg::CSR_CUTOFF_SLOPE:    cfg_ff.cutoff_slope    <= $signed(csr_wr_data);
            lplr_pkg::CSR_CUTOFF_CURVE:    cfg_ff.cutoff_curve    <= $signed(csr_wr_data);
            lplr_pkg::CSR_RESONANCE_START: cfg_ff.resonance_start <= csr_wr_data;
            lplr_pkg::CSR_RESONANCE_SLOPE: cfg_ff.resonance_slope <= $signed(csr_wr_data);
            lplr_pkg::CSR_RESONANCE_CURVE: cfg_ff.resonance_curve <= $signed(csr_wr_data);
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer, ramps, multiplier
   lplr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_acc),
      .stereo   (stereo),
      .out_free (out_free),
      .ctrl     (ctrl),
      .stat     (stat)
   );

   lplr_ramp u_ramp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .reload        (req_acc && req_data.first_of_block),
      .advance       (stat.finish),
      .cutoff_now    (cutoff_now),
      .resonance_now (resonance_now)
   );

   assign mul_en = (ctrl.mop != lplr_pkg::OP_NONE);

   lplr_mul u_mul (
      .clock  (clock),
      .enable (mul_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod)
   );

   // ------------------------------------------------------------------
   // Pole state: one read port, one write port per array
   assign rd_addr = ADDR_W'({ctrl.lane, ctrl.rd_pole});
   assign wr_addr = ADDR_W'({ctrl.lane, ctrl.wr_pole});
   assign pout_rd = pout_ff[rd_addr];
   assign pin_rd  = pin_ff[rd_addr];

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctrl.mop)
         lplr_pkg::OP_CUT_K116: begin
            op_a = OPW'(cutoff_now);
            op_b = OPW'(lplr_pkg::K_116);
         end
         lplr_pkg::OP_F_F: begin
            op_a = OPW'(f_ff);
            op_b = OPW'(f_ff);
         end
         lplr_pkg::OP_F2_F2: begin
            op_a = OPW'(f2_ff);
            op_b = OPW'(f2_ff);
         end
         lplr_pkg::OP_K015_F2: begin
            op_a = OPW'(lplr_pkg::K_015);
            op_b = OPW'(f2_ff);
         end
         lplr_pkg::OP_K035_F4: begin
            op_a = OPW'(lplr_pkg::K_035);
            op_b = OPW'(f4_ff);
         end
         lplr_pkg::OP_RES_V: begin
            op_a = OPW'(resonance_now);
            op_b = OPW'(v_ff);
         end
         lplr_pkg::OP_OUT3_FB: begin
            op_a = OPW'(pout_rd);
            op_b = OPW'(fb_ff);
         end
         lplr_pkg::OP_X_G: begin
            op_a = OPW'(x_ff);
            op_b = OPW'(g_ff);
         end
         lplr_pkg::OP_K030_IN: begin
            op_a = OPW'(lplr_pkg::K_030);
            op_b = OPW'(pin_rd);
         end
         lplr_pkg::OP_D_OUT: begin
            op_a = OPW'(d_ff);
            op_b = OPW'(pout_rd);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Product shifted down by 30 with floor rounding
   assign psh        = prod[67:30];
   assign sample_sel = ctrl.lane ? smp_ff.sample_right : smp_ff.sample_left;
   assign x0         = lplr_pkg::sat32(36'(sample_sel) - psh[35:0]);
   assign ysum       = 36'(x_ff) + 36'(acc_ff) + psh[35:0];
   assign y          = lplr_pkg::sat32(ysum);
   assign y_smp      = lplr_pkg::sat_sample(y);

   // ------------------------------------------------------------------
   // Datapath registers fed from the product
   always_ff @(posedge clock) begin
      if (req_acc) begin
         smp_ff <= req_data;
      end
      unique case (ctrl.use_op)
         lplr_pkg::USE_F: begin
            f_ff <= prod[62:32];
            d_ff <= 32'(lplr_pkg::ONE_Q30) - $signed({1'b0, prod[62:32]});
         end
         lplr_pkg::USE_F2:  f2_ff <= prod[60:30];
         lplr_pkg::USE_F4:  f4_ff <= prod[60:30];
         lplr_pkg::USE_V:   v_ff  <= lplr_pkg::ONE_Q30 - prod[60:30];
         lplr_pkg::USE_G:   g_ff  <= prod[59:30];
         lplr_pkg::USE_FB:  fb_ff <= prod[61:30];
         lplr_pkg::USE_X0:  x_ff  <= x0;
         lplr_pkg::USE_XG:  x_ff  <= psh[31:0];
         lplr_pkg::USE_ACC: acc_ff <= psh[31:0];
         lplr_pkg::USE_POLE: begin
            x_ff <= y;
            if (ctrl.wr_pole == 2'd3) begin
               if (ctrl.lane) begin
                  right_ff <= y_smp;
               end else begin
                  left_ff <= y_smp;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NPOLE; i++) begin
            pout_ff[i] <= '0;
            pin_ff[i]  <= '0;
         end
      end else if (ctrl.use_op == lplr_pkg::USE_POLE) begin
         pin_ff[wr_addr]  <= x_ff;
         pout_ff[wr_addr] <= y;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.finish) begin
         rsp_data_ff.filtered_left  <= left_ff;
         rsp_data_ff.filtered_right <= stereo ? right_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("block not busy after taking a frame");

   a_result_after_finish: assert property (@(posedge clock) disable iff (reset)
      stat.finish |=> rsp_valid)
      else $error("finished frame not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !stat.finish)
      else $error("stalled result overwritten");

   a_pole_write_busy: assert property (@(posedge clock) disable iff (reset)
      (ctrl.use_op == lplr_pkg::USE_POLE) |-> stat.busy)
      else $error("pole state written while idle");
`endif

endmodule

FILE: rtl/lplr_mul.sv
// Shared signed multiplier with a registered product.
// Depends on lplr_pkg for operand and product widths.
module lplr_mul (
   input  logic                                       clock,
   input  logic                                       enable,
   input  logic signed [lplr_pkg::LPLR_OP_W-1:0]      op_a,
   input  logic signed [lplr_pkg::LPLR_OP_W-1:0]      op_b,
   output logic signed [lplr_pkg::LPLR_PROD_W-1:0]    prod
);

   logic signed [lplr_pkg::LPLR_PROD_W-1:0] prod_ff;
   logic signed [lplr_pkg::LPLR_PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/lplr_ramp.sv
// Second-order ramps for cutoff and resonance: value gains slope, slope gains curve.
// Depends on lplr_pkg for the configuration struct and reset constants.
module lplr_ramp (
   input  logic                  clock,
   input  logic                  reset,
   input  lplr_pkg::lplr_cfg_type cfg,
   input  logic                  reload,
   input  logic                  advance,
   output logic [31:0]           cutoff_now,
   output logic [31:0]           resonance_now
);

   logic        [31:0] cut_now_ff, cut_now_in;
   logic signed [32:0] cut_step_ff, cut_step_in;
   logic        [31:0] res_now_ff, res_now_in;
   logic signed [32:0] res_step_ff, res_step_in;

   // Value plus step, held in 0 .. 2^32-1
   function automatic logic [31:0] now_next(input logic [31:0] now,
                                            input logic signed [32:0] step);
      logic signed [34:0] sum;
      sum = $signed({3'b000, now}) + 35'(step);
      if (sum < 35'sd0) begin
         return 32'd0;
      end else if (sum > 35'sd4294967295) begin
         return 32'hFFFF_FFFF;
      end
      return sum[31:0];
   endfunction

   // Step plus curve, held in -2^32 .. 2^32-1
   function automatic logic signed [32:0] step_next(input logic signed [32:0] step,
                                                    input logic signed [31:0] curve);
      logic signed [33:0] sum;
      sum = 34'(step) + 34'(curve);
      if (sum > 34'sd4294967295) begin
         return 33'sh0_FFFF_FFFF;
      end else if (sum < -34'sd4294967296) begin
         return 33'sh1_0000_0000;
      end
      return sum[32:0];
   endfunction

   always_comb begin
      cut_now_in  = cut_now_ff;
      cut_step_in = cut_step_ff;
      res_now_in  = res_now_ff;
      res_step_in = res_step_ff;
      if (reload) begin
         cut_now_in  = cfg.cutoff_start;
         cut_step_in = 33'(cfg.cutoff_slope);
         res_now_in  = cfg.resonance_start;
         res_step_in = 33'(cfg.resonance_slope);
      end else if (advance) begin
         cut_now_in  = now_next(cut_now_ff, cut_step_ff);
         cut_step_in = step_next(cut_step_ff, cfg.cutoff_curve);
         res_now_in  = now_next(res_now_ff, res_step_ff);
         res_step_in = step_next(res_step_ff, cfg.resonance_curve);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_now_ff  <= lplr_pkg::CUTOFF_START_RST;
         cut_step_ff <= '0;
         res_now_ff  <= '0;
         res_step_ff <= '0;
      end else begin
         cut_now_ff  <= cut_now_in;
         cut_step_ff <= cut_step_in;
         res_now_ff  <= res_now_in;
         res_step_ff <= res_step_in;
      end
   end

   assign cutoff_now    = cut_now_ff;
   assign resonance_now = res_now_ff;

endmodule

FILE: rtl/lplr_seq.sv
// Sequencer: steps the coefficient pass and the per-lane pole passes through the multiplier.
// Depends on lplr_pkg for state, micro-op and status types.
module lplr_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    stereo,
   input  logic                    out_free,
   output lplr_pkg::lplr_ctrl_type ctrl,
   output lplr_pkg::lplr_stat_type stat
);

   localparam logic [3:0] COEF_LAST = 4'd8;
   localparam logic [3:0] LANE_LAST = 4'd10;

   lplr_pkg::lplr_state_type state_ff, state_in;
   logic [3:0]               step_ff, step_in;
   logic                     lane_ff, lane_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lplr_pkg::ST_IDLE;
         step_ff  <= '0;
         lane_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         lane_ff  <= lane_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      lane_in      = lane_ff;
      ctrl.mop     = lplr_pkg::OP_NONE;
      ctrl.use_op  = lplr_pkg::USE_NONE;
      ctrl.rd_pole = 2'd0;
      ctrl.wr_pole = 2'd0;
      ctrl.lane    = lane_ff;
      stat.busy    = (state_ff != lplr_pkg::ST_IDLE);
      stat.finish  = 1'b0;

      unique case (state_ff)
         lplr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lplr_pkg::ST_COEF;
               step_in  = '0;
               lane_in  = 1'b0;
            end
         end
         lplr_pkg::ST_COEF: begin
            unique case (step_ff)
               4'd0: ctrl.mop = lplr_pkg::OP_CUT_K116;
               4'd1: ctrl.use_op = lplr_pkg::USE_F;
               4'd2: ctrl.mop = lplr_pkg::OP_F_F;
               4'd3: ctrl.use_op = lplr_pkg::USE_F2;
               4'd4: ctrl.mop = lplr_pkg::OP_F2_F2;
               4'd5: begin
                  ctrl.mop    = lplr_pkg::OP_K015_F2;
                  ctrl.use_op = lplr_pkg::USE_F4;
               end
               4'd6: begin
                  ctrl.mop    = lplr_pkg::OP_K035_F4;
                  ctrl.use_op = lplr_pkg::USE_V;
               end
               4'd7: begin
                  ctrl.mop    = lplr_pkg::OP_RES_V;
                  ctrl.use_op = lplr_pkg::USE_G;
               end
               4'd8: ctrl.use_op = lplr_pkg::USE_FB;
               default: ctrl.mop = lplr_pkg::OP_NONE;
            endcase
            if (step_ff == COEF_LAST) begin
               state_in = lplr_pkg::ST_LANE;
               step_in  = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         lplr_pkg::ST_LANE: begin
            // Products of in_k and out_k are issued ahead; the sum waits for x.
            unique case (step_ff)
               4'd0: begin
                  ctrl.mop     = lplr_pkg::OP_OUT3_FB;
                  ctrl.rd_pole = 2'd3;
               end
               4'd1: begin
                  ctrl.mop     = lplr_pkg::OP_K030_IN;
                  ctrl.use_op  = lplr_pkg::USE_X0;
                  ctrl.rd_pole = 2'd0;
               end
               4'd2: begin
                  ctrl.mop    = lplr_pkg::OP_X_G;
                  ctrl.use_op = lplr_pkg::USE_ACC;
               end
               4'd3: begin
                  ctrl.mop     = lplr_pkg::OP_D_OUT;
                  ctrl.use_op  = lplr_pkg::USE_XG;
                  ctrl.rd_pole = 2'd0;
               end
               4'd4: begin
                  ctrl.mop     = lplr_pkg::OP_K030_IN;
                  ctrl.use_op  = lplr_pkg::USE_POLE;
                  ctrl.rd_pole = 2'd1;
                  ctrl.wr_pole = 2'd0;
               end
               4'd5: begin
                  ctrl.mop     = lplr_pkg::OP_D_OUT;
                  ctrl.use_op  = lplr_pkg::USE_ACC;
                  ctrl.rd_pole = 2'd1;
               end
               4'd6: begin
                  ctrl.mop     = lplr_pkg::OP_K030_IN;
                  ctrl.use_op  = lplr_pkg::USE_POLE;
                  ctrl.rd_pole = 2'd2;
                  ctrl.wr_pole = 2'd1;
               end
               4'd7: begin
                  ctrl.mop     = lplr_pkg::OP_D_OUT;
                  ctrl.use_op  = lplr_pkg::USE_ACC;
                  ctrl.rd_pole = 2'd2;
               end
               4'd8: begin
                  ctrl.mop     = lplr_pkg::OP_K030_IN;
                  ctrl.use_op  = lplr_pkg::USE_POLE;
                  ctrl.rd_pole = 2'd3;
                  ctrl.wr_pole = 2'd2;
               end
               4'd9: begin
                  ctrl.mop     = lplr_pkg::OP_D_OUT;
                  ctrl.use_op  = lplr_pkg::USE_ACC;
                  ctrl.rd_pole = 2'd3;
               end
               4'd10: begin
                  ctrl.use_op  = lplr_pkg::USE_POLE;
                  ctrl.wr_pole = 2'd3;
               end
               default: ctrl.mop = lplr_pkg::OP_NONE;
            endcase
            if (step_ff == LANE_LAST) begin
               step_in = '0;
               if (!lane_ff && stereo) begin
                  lane_in = 1'b1;
               end else begin
                  state_in = lplr_pkg::ST_FINISH;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         lplr_pkg::ST_FINISH: begin
            // hold until the output register can take the beat
            stat.finish = out_free;
            if (out_free) begin
               state_in = lplr_pkg::ST_IDLE;
            end
         end
         default: state_in = lplr_pkg::ST_IDLE;
      endcase
   end

endmodule
